FILE: rtl/ffba_pkg.sv
// Shared constants, types and helper functions for the first-fit bitmap allocator.
`default_nettype none

package ffba_pkg;

  localparam int MEM_CELLS = 1024;
  localparam int WORD_W    = (MEM_CELLS < 32) ? MEM_CELLS : 32;
  localparam int NUM_WORDS = MEM_CELLS / WORD_W;
  localparam int CNT_W     = $clog2(MEM_CELLS + 1);
  localparam int WOFF_W    = $clog2(WORD_W);
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int OP_W      = 2;
  localparam int LEN_W     = 11;
  localparam int POS_W     = 10;
  localparam int CALC_W    = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic             REG_RESERVE = 1'b0;
  localparam logic [POS_W-1:0] RESERVE_RST = 10'd64;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [WIDX_W-1:0] widx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef struct packed {
    logic  rd_en;
    widx_t rd_idx;
    logic  wr_en;
    widx_t wr_idx;
    word_t wr_data;
    logic  clr;
  } bmap_req_t;

  typedef struct packed {
    logic hit;
    cnt_t start;
    len_t run;
  } scan_res_t;

  // Cell index of bit 0 of a bitmap word.
  function automatic cnt_t word_base(widx_t w);
    return CNT_W'({w, {WOFF_W{1'b0}}});
  endfunction

  // Bits of the word whose cell index lies in [lo, hi).
  function automatic word_t range_mask(cnt_t base, cnt_t lo, cnt_t hi);
    logic [CNT_W:0] pos;
    word_t          m;
    m = '0;
    for (int j = 0; j < WORD_W; j++) begin
      pos  = {1'b0, base} + (CNT_W+1)'(j);
      m[j] = (pos >= {1'b0, lo}) && (pos < {1'b0, hi});
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ffba_bitmap.sv
// Word-wide used/free bitmap with per-row valid bits and registered read.
`default_nettype none

module ffba_bitmap
  import ffba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire bmap_req_t req,
  output logic [WORD_W-1:0] rd_word
);

  word_t                 mem_r [NUM_WORDS];
  logic [NUM_WORDS-1:0]  row_vld_r;
  word_t                 rd_data_r;
  logic                  rd_vld_r;

  // Rows never written since reset or clear read as all free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (req.clr) begin
      row_vld_r <= '0;
    end else if (req.wr_en) begin
      row_vld_r[req.wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_idx] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_idx];
      rd_vld_r  <= row_vld_r[req.rd_idx];
    end
  end

  assign rd_word = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

FILE: rtl/ffba_scan.sv
// One-word first-fit scan step: finds where a free run reaches the request length.
`default_nettype none

module ffba_scan
  import ffba_pkg::*;
(
  input  wire logic [WORD_W-1:0] used,
  input  wire logic [LEN_W-1:0]  run_in,
  input  wire logic [LEN_W-1:0]  len,
  input  wire logic [CNT_W-1:0]  base,
  output scan_res_t              res
);

  word_t              top_ones;
  word_t              ok;
  len_t               thr;
  logic [WOFF_W-1:0]  pos;
  logic [WOFF_W-1:0]  top_free;
  logic [CALC_W-1:0]  start_c;

  always_comb begin
    // len ones aligned to the MSB; shifted down, they cover cells [j-len+1, j]
    top_ones = ~({WORD_W{1'b1}} >> len);
    thr      = len - run_in;
    for (int j = 0; j < WORD_W; j++) begin
      ok[j] = ~|(used & (top_ones >> (WORD_W - 1 - j))) && (LEN_W'(j + 1) >= thr);
    end

    pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (ok[j]) begin
        pos = WOFF_W'(j);
      end
    end

    // free cells above the highest used one carry into the next word
    top_free = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (used[j]) begin
        top_free = WOFF_W'(WORD_W - 1 - j);
      end
    end

    start_c = CALC_W'(base) + CALC_W'(pos) + CALC_W'(1) - CALC_W'(len);

    res.hit   = |ok;
    res.start = CNT_W'(start_c);
    res.run   = (used == '0) ? (run_in + LEN_W'(WORD_W)) : LEN_W'(top_free);
  end

endmodule

`default_nettype wire

FILE: rtl/first_fit_bitmap_allocator_top.sv
// Allocate reads and scans each bitmap word from the reserve word to the hit word
// (S_SCAN_RD, S_SCAN_EV), then read-modify-writes each word touched (S_RNG_RD,
// S_RNG_WR); free read-modify-writes each word touched. Clear, no-op and trivial
// requests go straight to S_DONE. A new request is taken only in S_IDLE.
// Synchronous active-low reset frees every cell and sets reserve to 64; no sweep.
`default_nettype none

module first_fit_bitmap_allocator_top
  import ffba_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [LEN_W-1:0]  in_req_size,
  input  wire logic [POS_W-1:0]  in_start_addr,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_granted,
  output logic [POS_W-1:0]       out_block_start,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_RNG_RD,
    S_RNG_WR,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  widx_t             widx_r, widx_nxt;
  widx_t             last_r, last_nxt;
  len_t              run_r, run_nxt;
  len_t              len_r, len_nxt;
  cnt_t              lo_r, lo_nxt;
  cnt_t              hi_r, hi_nxt;
  logic              set_r, set_nxt;
  logic              grant_r, grant_nxt;
  logic [POS_W-1:0]  start_r, start_nxt;
  logic [POS_W-1:0]  reserve_r, reserve_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_granted_r, out_granted_nxt;
  logic [POS_W-1:0]  out_start_r, out_start_nxt;

  bmap_req_t         bm_req;
  word_t             rd_word;
  word_t             rng_mask;
  word_t             scan_used;
  word_t             wr_word;
  cnt_t              cur_base;
  scan_res_t         scan_res;
  logic              in_acc;
  logic              out_hold;
  logic              rsv_oob;
  logic              start_oob;
  logic [CALC_W-1:0] free_end;
  cnt_t              free_hi;
  cnt_t              alloc_hi;

  ffba_bitmap u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (bm_req),
    .rd_word (rd_word)
  );

  ffba_scan u_scan (
    .used   (scan_used),
    .run_in (run_r),
    .len    (len_r),
    .base   (cur_base),
    .res    (scan_res)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_hold = out_valid_r && out_stall;

  assign cur_base  = word_base(widx_r);
  assign rng_mask  = range_mask(cur_base, lo_r, hi_r);
  // cells below the reserve look used to the scan
  assign scan_used = rd_word | range_mask(cur_base, '0, CNT_W'(reserve_r));
  assign wr_word   = set_r ? (rd_word | rng_mask) : (rd_word & ~rng_mask);

  assign rsv_oob   = CALC_W'(reserve_r) >= CALC_W'(MEM_CELLS);
  assign start_oob = CALC_W'(in_start_addr) >= CALC_W'(MEM_CELLS);
  assign free_end  = CALC_W'(in_start_addr) + CALC_W'(in_req_size);
  assign free_hi   = (free_end > CALC_W'(MEM_CELLS)) ? CNT_W'(MEM_CELLS) : CNT_W'(free_end);
  assign alloc_hi  = CNT_W'(CALC_W'(scan_res.start) + CALC_W'(len_r));

  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1] == REG_RESERVE) ? CFG_DW'(reserve_r) : '0;

  always_comb begin
    state_nxt       = state_r;
    widx_nxt        = widx_r;
    last_nxt        = last_r;
    run_nxt         = run_r;
    len_nxt         = len_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    set_nxt         = set_r;
    grant_nxt       = grant_r;
    start_nxt       = start_r;
    reserve_nxt     = reserve_r;
    out_valid_nxt   = out_hold;
    out_granted_nxt = out_granted_r;
    out_start_nxt   = out_start_r;

    bm_req         = '0;
    bm_req.rd_idx  = widx_r;
    bm_req.wr_idx  = widx_r;
    bm_req.wr_data = wr_word;

    if (psel && penable && pwrite && pready && (paddr[CFG_AW-1] == REG_RESERVE)) begin
      reserve_nxt = pwdata[POS_W-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          grant_nxt = 1'b1;
          start_nxt = '0;
          state_nxt = S_DONE;
          case (in_op)
            OP_ALLOC: begin
              if ((in_req_size == '0) || rsv_oob) begin
                grant_nxt = 1'b0;
              end else begin
                len_nxt   = in_req_size;
                run_nxt   = '0;
                widx_nxt  = WIDX_W'(reserve_r >> WOFF_W);
                state_nxt = S_SCAN_RD;
              end
            end
            OP_FREE: begin
              if ((in_req_size != '0) && !start_oob) begin
                lo_nxt    = CNT_W'(in_start_addr);
                hi_nxt    = free_hi;
                widx_nxt  = WIDX_W'(CNT_W'(in_start_addr) >> WOFF_W);
                last_nxt  = WIDX_W'((free_hi - CNT_W'(1)) >> WOFF_W);
                set_nxt   = 1'b0;
                state_nxt = S_RNG_RD;
              end
            end
            OP_CLEAR: begin
              bm_req.clr = 1'b1;
            end
            default: begin
              grant_nxt = 1'b0;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        bm_req.rd_en = 1'b1;
        state_nxt    = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (scan_res.hit) begin
          lo_nxt    = scan_res.start;
          hi_nxt    = alloc_hi;
          widx_nxt  = WIDX_W'(scan_res.start >> WOFF_W);
          last_nxt  = WIDX_W'((alloc_hi - CNT_W'(1)) >> WOFF_W);
          set_nxt   = 1'b1;
          start_nxt = POS_W'(scan_res.start);
          state_nxt = S_RNG_RD;
        end else if (widx_r == WIDX_W'(NUM_WORDS - 1)) begin
          grant_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          widx_nxt  = widx_r + WIDX_W'(1);
          run_nxt   = scan_res.run;
          state_nxt = S_SCAN_RD;
        end
      end
      S_RNG_RD: begin
        bm_req.rd_en = 1'b1;
        state_nxt    = S_RNG_WR;
      end
      S_RNG_WR: begin
        bm_req.wr_en = 1'b1;
        if (widx_r == last_r) begin
          state_nxt = S_DONE;
        end else begin
          widx_nxt  = widx_r + WIDX_W'(1);
          state_nxt = S_RNG_RD;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_hold) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = grant_r;
          out_start_nxt   = grant_r ? start_r : '0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      reserve_r   <= RESERVE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      reserve_r   <= reserve_nxt;
    end
    widx_r        <= widx_nxt;
    last_r        <= last_nxt;
    run_r         <= run_nxt;
    len_r         <= len_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    set_r         <= set_nxt;
    grant_r       <= grant_nxt;
    start_r       <= start_nxt;
    out_granted_r <= out_granted_nxt;
    out_start_r   <= out_start_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_block_start = out_start_r;

`ifndef ASSERT_OFF
  a_fail_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_block_start == '0))
    else $error("failed result carries a nonzero start");

  a_hit_above_reserve: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN_EV) && scan_res.hit) |-> (scan_res.start >= CNT_W'(reserve_r)))
    else $error("allocation hit below the reserve");

  a_range_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RNG_WR) |-> (widx_r <= last_r))
    else $error("range update ran past its last word");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted word");
`endif

endmodule

`default_nettype wire
